/* rtl/core/subnet_acl_match_unit_assert.svh */
// assertion macros for the subnet acl match unit checker
// expects clk and rst_n in the scope where a macro is used
`ifndef SUBNET_ACL_MATCH_UNIT_ASSERT_SVH
`define SUBNET_ACL_MATCH_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SAM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sam_pkg.sv */
// shared types, constants and helpers of the subnet acl match unit
// no dependencies
`default_nettype none

package sam_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned ADDR_BYTES_DEF  = 16;

  localparam int unsigned ADDR_W    = 128;
  localparam int unsigned HALF_W    = 64;
  localparam int unsigned PFX_W     = 8;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned CFG_IDX_W = 8;

  // item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // mode code that lets every address through
  localparam logic [MODE_W-1:0] MODE_OPEN = 2'd0;
  // reset mode code; like every mode but open, it checks the entries, then the local address
  localparam logic [MODE_W-1:0] MODE_LOCAL = 2'd1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE        = 8'd0,
    REG_ENTRY_COUNT = 8'd1,
    REG_LOCAL_HI    = 8'd2,
    REG_LOCAL_LO    = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COUNT_W-1:0] entry_count;
    logic [HALF_W-1:0]  local_hi;
    logic [HALF_W-1:0]  local_lo;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic store;
    logic rd_en;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cmp_valid;
    logic cmp_hit;
    logic local_eq;
  } dp_stat_t;

  // standard prefix mask, leading plen bits set, plen from 0 to 128
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PFX_W-1:0] plen);
    return ~({ADDR_W{1'b1}} >> plen);
  endfunction

  // index width of a table with the given depth
  function automatic int unsigned idx_width(input int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/sam_if.sv */
// valid/ready channel interfaces: item input, result output, config write
// depends on sam_pkg
`default_nettype none

interface sam_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [3:0]                  entry_index;
  logic [sam_pkg::PFX_W-1:0]   prefix_len;
  logic [sam_pkg::HALF_W-1:0]  addr_hi;
  logic [sam_pkg::HALF_W-1:0]  addr_lo;

  modport source (output valid, op, entry_index, prefix_len, addr_hi, addr_lo,
                  input ready);
  modport sink   (input valid, op, entry_index, prefix_len, addr_hi, addr_lo,
                  output ready);
endinterface

interface sam_out_if;
  logic valid;
  logic ready;
  logic allowed;
  logic local_match;

  modport source (output valid, allowed, local_match, input ready);
  modport sink   (input valid, allowed, local_match, output ready);
endinterface

interface sam_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sam_pkg::CFG_IDX_W-1:0] reg_index;
  logic [sam_pkg::HALF_W-1:0]    wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

/* rtl/core/subnet_acl_match_unit.sv */
// Subnet access-control matcher for 128-bit addresses.
//
// Input channel in_ch carries one word per item. op 0 stores a subnet entry:
// the address masked to prefix_len (saturated to the significant width) goes
// into slot entry_index; a slot past the table is ignored. A write gives no
// result. op 1 checks an address and gives one result word
// on out_ch: allowed, and local_match when only the local address matched.
// Open mode allows at once; other modes search entries below entry_count,
// then compare with the local address.
// In open mode a check goes straight to the hold state. Otherwise the scan
// makes one table read per cycle through the single read port, stops at the
// first hit, and after a miss compares with the local address, then holds the
// result; in_ready is low for the whole check.
// The result sits in an output register; the next item is taken while it
// waits, and a stalled out_ch only holds a later check in its last step.
// cfg_ch writes mode, entry_count and the local address, one word per cycle,
// and is always ready; write it only while idle.
// Reset (rst_n low, synchronous) sets mode 1, count 0, local address 0 and
// drops any pending result. Table entries are undefined until written.
`default_nettype none

module subnet_acl_match_unit #(
  parameter int unsigned MAX_ENTRIES = sam_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned ADDR_BYTES  = sam_pkg::ADDR_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sam_in_if.sink    in_ch,
  sam_out_if.source out_ch,
  sam_cfg_if.sink   cfg_ch
);

  localparam int unsigned IDX_W = sam_pkg::idx_width(MAX_ENTRIES);

  sam_pkg::cfg_t     cfg;
  sam_pkg::dp_cmd_t  cmd;
  sam_pkg::dp_stat_t stat;
  logic [IDX_W-1:0]  rd_addr;

  // configuration registers
  sam_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_ch.valid),
    .cfg_index (cfg_ch.reg_index),
    .cfg_data  (cfg_ch.wr_data),
    .cfg_ready (cfg_ch.ready),
    .cfg       (cfg)
  );

  // sequencing and output word
  sam_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_op       (in_ch.op),
    .in_ready    (in_ch.ready),
    .cfg         (cfg),
    .stat        (stat),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .out_valid   (out_ch.valid),
    .out_allowed (out_ch.allowed),
    .out_local   (out_ch.local_match),
    .out_ready   (out_ch.ready)
  );

  // table and compares
  sam_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ADDR_BYTES  (ADDR_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .entry_index (in_ch.entry_index),
    .prefix_len  (in_ch.prefix_len),
    .addr_hi     (in_ch.addr_hi),
    .addr_lo     (in_ch.addr_lo),
    .cfg         (cfg),
    .stat        (stat)
  );

endmodule

`default_nettype wire

/* rtl/core/sam_cfg.sv */
// configuration register file: mode, entry count, local address
// depends on sam_pkg
`default_nettype none

module sam_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [sam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sam_pkg::HALF_W-1:0]    cfg_data,
  output logic                          cfg_ready,
  output sam_pkg::cfg_t                 cfg
);

  logic [sam_pkg::MODE_W-1:0]  mode_r, mode_nxt;
  logic [sam_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [sam_pkg::HALF_W-1:0]  local_hi_r, local_hi_nxt;
  logic [sam_pkg::HALF_W-1:0]  local_lo_r, local_lo_nxt;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register decode, unknown indexes are dropped
  always_comb begin
    mode_nxt     = mode_r;
    count_nxt    = count_r;
    local_hi_nxt = local_hi_r;
    local_lo_nxt = local_lo_r;
    if (cfg_valid) begin
      case (cfg_index)
        sam_pkg::REG_MODE:        mode_nxt     = cfg_data[sam_pkg::MODE_W-1:0];
        sam_pkg::REG_ENTRY_COUNT: count_nxt    = cfg_data[sam_pkg::COUNT_W-1:0];
        sam_pkg::REG_LOCAL_HI:    local_hi_nxt = cfg_data;
        sam_pkg::REG_LOCAL_LO:    local_lo_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= sam_pkg::MODE_LOCAL;
      count_r    <= '0;
      local_hi_r <= '0;
      local_lo_r <= '0;
    end else begin
      mode_r     <= mode_nxt;
      count_r    <= count_nxt;
      local_hi_r <= local_hi_nxt;
      local_lo_r <= local_lo_nxt;
    end
  end

  assign cfg.mode        = mode_r;
  assign cfg.entry_count = count_r;
  assign cfg.local_hi    = local_hi_r;
  assign cfg.local_lo    = local_lo_r;

endmodule

`default_nettype wire

/* rtl/core/sam_dp.sv */
// datapath: item register, subnet table memory, prefix compare, local compare
// depends on sam_pkg
`default_nettype none

module sam_dp #(
  parameter int unsigned MAX_ENTRIES = sam_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned ADDR_BYTES  = sam_pkg::ADDR_BYTES_DEF,
  localparam int unsigned IDX_W      = sam_pkg::idx_width(MAX_ENTRIES)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sam_pkg::dp_cmd_t            cmd,
  input  logic [IDX_W-1:0]            rd_addr,
  input  logic [3:0]                  entry_index,
  input  logic [sam_pkg::PFX_W-1:0]   prefix_len,
  input  logic [sam_pkg::HALF_W-1:0]  addr_hi,
  input  logic [sam_pkg::HALF_W-1:0]  addr_lo,
  input  sam_pkg::cfg_t               cfg,
  output sam_pkg::dp_stat_t           stat
);

  localparam logic [sam_pkg::PFX_W-1:0]  FULL_PFX = sam_pkg::PFX_W'(ADDR_BYTES * 8);
  localparam logic [sam_pkg::ADDR_W-1:0] SIG_MASK = sam_pkg::prefix_mask(FULL_PFX);

  logic [sam_pkg::ADDR_W-1:0] mem_addr [MAX_ENTRIES];
  logic [sam_pkg::PFX_W-1:0]  mem_pfx  [MAX_ENTRIES];

  logic [sam_pkg::ADDR_W-1:0] in_addr;
  logic [sam_pkg::PFX_W-1:0]  wr_pfx;
  logic [IDX_W-1:0]           wr_addr;
  logic                       wr_en;

  logic [sam_pkg::ADDR_W-1:0] item_addr_r;
  logic [sam_pkg::ADDR_W-1:0] rd_data_r;
  logic [sam_pkg::PFX_W-1:0]  rd_pfx_r;
  logic                       rd_valid_r;

  // significant bytes of the incoming address
  assign in_addr = {addr_hi, addr_lo} & SIG_MASK;

  // write side: saturate the prefix, drop slots past the table
  assign wr_pfx  = (prefix_len > FULL_PFX) ? FULL_PFX : prefix_len;
  assign wr_addr = IDX_W'(entry_index);
  assign wr_en   = cmd.store && (32'(entry_index) < MAX_ENTRIES);

  // item address held for the whole check
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_addr_r <= in_addr;
    end
  end

  // table write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_addr[wr_addr] <= in_addr & sam_pkg::prefix_mask(wr_pfx);
      mem_pfx[wr_addr]  <= wr_pfx;
    end
  end

  // table read port, registered data
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem_addr[rd_addr];
      rd_pfx_r  <= mem_pfx[rd_addr];
    end
  end

  // read data valid in the cycle after the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.rd_en;
    end
  end

  // entry compare under the entry's own prefix, local address compare
  assign stat.cmp_valid = rd_valid_r;
  assign stat.cmp_hit   = (item_addr_r & sam_pkg::prefix_mask(rd_pfx_r)) == rd_data_r;
  assign stat.local_eq  = item_addr_r == ({cfg.local_hi, cfg.local_lo} & SIG_MASK);

endmodule

`default_nettype wire

/* rtl/core/sam_ctrl.sv */
// controller: accepts items, walks the table, holds the result word
// depends on sam_pkg
`default_nettype none

module sam_ctrl #(
  parameter int unsigned MAX_ENTRIES = sam_pkg::MAX_ENTRIES_DEF,
  localparam int unsigned IDX_W      = sam_pkg::idx_width(MAX_ENTRIES),
  localparam int unsigned CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  input  sam_pkg::cfg_t     cfg,
  input  sam_pkg::dp_stat_t stat,
  output sam_pkg::dp_cmd_t  cmd,
  output logic [IDX_W-1:0]  rd_addr,
  output logic              out_valid,
  output logic              out_allowed,
  output logic              out_local,
  input  logic              out_ready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOCAL,
    ST_HOLD
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] n_lim;
  logic             res_allow_r;
  logic             res_local_r;
  logic             out_valid_r;
  logic             out_allow_r;
  logic             out_local_r;
  logic             accept;
  logic             load_out;

  // entries in use, clipped to the table depth
  assign n_lim = (32'(cfg.entry_count) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                      : CNT_W'(cfg.entry_count);

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign cmd.load  = accept;
  assign cmd.store = accept && (in_op == sam_pkg::OP_WRITE);
  assign cmd.rd_en = (state_r == ST_SCAN) && (cnt_r < n_lim);
  assign rd_addr   = cnt_r[IDX_W-1:0];

  // result moves to the output register once it is free or being taken
  assign load_out = (state_r == ST_HOLD) && (!out_valid_r || out_ready);

  assign out_valid   = out_valid_r;
  assign out_allowed = out_allow_r;
  assign out_local   = out_local_r;

  // state, scan counter, pending result and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output word: load a new result, else clear once taken
      if (load_out) begin
        out_valid_r <= 1'b1;
        out_allow_r <= res_allow_r;
        out_local_r <= res_local_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept && (in_op == sam_pkg::OP_CHECK)) begin
            cnt_r <= '0;
            if (cfg.mode == sam_pkg::MODE_OPEN) begin
              res_allow_r <= 1'b1;
              res_local_r <= 1'b0;
              state_r     <= ST_HOLD;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // first hit ends the walk; past the last entry try the local address
          if (stat.cmp_valid && stat.cmp_hit) begin
            res_allow_r <= 1'b1;
            res_local_r <= 1'b0;
            state_r     <= ST_HOLD;
          end else if (cnt_r == n_lim) begin
            state_r <= ST_LOCAL;
          end
        end
        ST_LOCAL: begin
          res_allow_r <= stat.local_eq;
          res_local_r <= stat.local_eq;
          state_r     <= ST_HOLD;
        end
        ST_HOLD: begin
          if (load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sam_chk.sv */
// port-level checker for the subnet acl match unit, bound to the top level
// depends on subnet_acl_match_unit_assert.svh
`default_nettype none

`include "subnet_acl_match_unit_assert.svh"

module sam_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_op,
  input logic out_valid,
  input logic out_ready,
  input logic out_allowed,
  input logic out_local
);

  // a pending result word is not dropped
  `SAM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word lost while stalled")

  // local match only ever comes with allowed
  `SAM_ASSERT_NOW(a_local_allowed, out_valid && out_local, out_allowed, "local match without allowed")

  // a check keeps the input closed while it runs
  `SAM_ASSERT_NEXT(a_check_busy, in_valid && in_ready && in_op, !in_ready, "input open during check")

  // a table write finishes in its accept cycle
  `SAM_ASSERT_NEXT(a_write_quick, in_valid && in_ready && !in_op, in_ready, "input closed after write")

endmodule

bind subnet_acl_match_unit sam_chk u_sam_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_op       (in_ch.op),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_allowed (out_ch.allowed),
  .out_local   (out_ch.local_match)
);

`default_nettype wire

/* dv/tb_top.sv */
// self-checking testbench for subnet_acl_match_unit: directed table, then random phases
// depends on sam_pkg, the sam channel interfaces and the subnet_acl_match_unit rtl
`timescale 1ns / 1ps

module tb_top;
  import sam_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 10;
  localparam int IDLE_PCT      = 12;
  localparam int DRAIN_CYCLES  = 32;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 14;
  localparam int PHASE_ITEMS   = 102;
  localparam int NO_IDLE_PHASE = 4;
  localparam int HOLD_PHASE    = 2;
  localparam int PAUSE_PHASE   = 7;
  localparam int TABLE_DEPTH   = 16;
  localparam int FULL_PREFIX   = 128;
  localparam longint unsigned LIMIT_NS = 64'd6_000_000;

  localparam logic [MODE_W-1:0]    MODE_LOCAL = 2'd1;
  localparam logic [MODE_W-1:0]    MODE_LIST  = 2'd2;
  localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd7;

  typedef struct packed {
    logic allowed;
    logic local_match;
  } verdict_t;

  localparam verdict_t V_ALLOW_LOCAL = 2'b11;
  localparam verdict_t V_ALLOW       = 2'b10;
  localparam verdict_t V_DENY        = 2'b00;

  typedef struct packed {
    logic              op;
    logic [3:0]        slot;
    logic [PFX_W-1:0]  plen;
    logic [HALF_W-1:0] hi;
    logic [HALF_W-1:0] lo;
  } acl_word_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  // one directed step: an item word, or a register write (sel = index, lo = data)
  typedef struct {
    row_kind_t         kind;
    logic              op;
    logic [7:0]        sel;
    logic [PFX_W-1:0]  plen;
    logic [HALF_W-1:0] hi;
    logic [HALF_W-1:0] lo;
    bit                known;
    verdict_t          want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  sam_in_if  in_ch ();
  sam_out_if out_ch ();
  sam_cfg_if cfg_ch ();

  subnet_acl_match_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #CLK_HALF clk = ~clk;

  // predicted acl state and configuration
  logic [MODE_W-1:0]  acl_mode;
  logic [COUNT_W-1:0] acl_count;
  logic [ADDR_W-1:0]  acl_local;
  logic [ADDR_W-1:0]  slot_addr [TABLE_DEPTH];
  logic [PFX_W-1:0]   slot_pfx  [TABLE_DEPTH];

  verdict_t verdicts_due [$];
  int       fail_count = 0;
  bit       steady     = 1'b0;
  int       hold_asked = 0;

  function automatic logic [ADDR_W-1:0] lead_ones(input int unsigned p);
    return (p == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - p));
  endfunction

  function automatic logic [ADDR_W-1:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // first matching entry wins, the local address only counts when no entry hits
  function automatic verdict_t acl_verdict(input logic [ADDR_W-1:0] a);
    verdict_t    v;
    int unsigned n;
    v = V_DENY;
    if (acl_mode == MODE_OPEN) begin
      return V_ALLOW;
    end
    n = (acl_count > TABLE_DEPTH) ? TABLE_DEPTH : acl_count;
    for (int unsigned i = 0; i < n && !v.allowed; i++) begin
      if ((a & lead_ones(slot_pfx[i])) == slot_addr[i]) v.allowed = 1'b1;
    end
    if (!v.allowed && a == acl_local) v = V_ALLOW_LOCAL;
    return v;
  endfunction

  // offer one word, then update the table or queue the verdict once taken
  task automatic send_word(input acl_word_t w, input bit known, input verdict_t want);
    int unsigned p;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= w.op;
    in_ch.entry_index <= w.slot;
    in_ch.prefix_len  <= w.plen;
    in_ch.addr_hi     <= w.hi;
    in_ch.addr_lo     <= w.lo;
    do @(posedge clk); while (!in_ch.ready);
    if (w.op == OP_WRITE) begin
      p = (w.plen > FULL_PREFIX) ? FULL_PREFIX : w.plen;
      slot_pfx[w.slot]  = PFX_W'(p);
      slot_addr[w.slot] = {w.hi, w.lo} & lead_ones(p);
    end else begin
      verdicts_due.push_back(known ? want : acl_verdict({w.hi, w.lo}));
    end
  endtask

  // stop offering, wait out every verdict, then let the block settle
  task automatic drain_block(input int settle);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // caller lowers cfg valid after the last write of a batch
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_MODE:        acl_mode  = data[MODE_W-1:0];
      REG_ENTRY_COUNT: acl_count = data[COUNT_W-1:0];
      REG_LOCAL_HI:    acl_local[ADDR_W-1:HALF_W] = data;
      REG_LOCAL_LO:    acl_local[HALF_W-1:0] = data;
      default: ;
    endcase
  endtask

  // stimulus: directed table, then random phases
  initial begin
    plan_row_t          plan [$];
    acl_word_t          w;
    logic [ADDR_W-1:0]  a;
    logic [HALF_W-1:0]  wide;
    logic [PFX_W-1:0]   plen_v;
    logic [MODE_W-1:0]  mode_v;
    logic [COUNT_W-1:0] count_v;
    int unsigned        j;
    int unsigned        pick;
    int unsigned        bitpos;
    bit                 prev_reg;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= OP_WRITE;
    in_ch.entry_index <= '0;
    in_ch.prefix_len  <= '0;
    in_ch.addr_hi     <= '0;
    in_ch.addr_lo     <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.reg_index  <= '0;
    cfg_ch.wr_data    <= '0;

    acl_mode  = MODE_LOCAL;
    acl_count = '0;
    acl_local = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot_addr[i] = '0;
      slot_pfx[i]  = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset: local only, local address zero, no entries in use
    plan.push_back(plan_row_t'{ROW_WORD, OP_CHECK, 8'd0, 8'd0, 64'h0, 64'h0, 1'b1,
                               V_ALLOW_LOCAL});
    plan.push_back(plan_row_t'{ROW_WORD, OP_CHECK, 8'd15, 8'hff, '1, '1, 1'b1, V_DENY});
    // fill every slot: prefix extremes, byte and half boundaries, saturation
    plan.push_back(plan_row_t'{ROW_WORD, OP_WRITE, 8'd0, 8'd128, '1, '1, 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_WRITE, 8'd1, 8'd255, 64'h0123_4567_89ab_cdef,
                               64'hfedc_ba98_7654_3210, 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_WRITE, 8'd2, 8'd64, 64'h2001_0db8_0000_0000,
                               64'h1111_2222_3333_4444, 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_WRITE, 8'd3, 8'd65, 64'h2001_0db8_aaaa_0000,
                               64'h8000_0000_0000_0001, 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_WRITE, 8'd4, 8'd63, 64'h2001_0db8_aaaa_0001,
                               64'hffff_0000_ffff_0000, 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_WRITE, 8'd5, 8'd1, 64'h8000_0000_0000_0000,
                               64'h0, 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_WRITE, 8'd6, 8'd127, 64'hc0a8_0001_0000_0000,
                               64'h0000_0000_0000_0003, 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_WRITE, 8'd7, 8'd8, 64'hfe80_1234_5678_9abc,
                               64'hdef0_1234_5678_9abc, 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_WRITE, 8'd8, 8'd129, 64'h0,
                               64'h0000_ffff_c0a8_0101, 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_WRITE, 8'd9, 8'd7, 64'hfc00_0000_0000_0000,
                               64'h1, 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_WRITE, 8'd10, 8'd9, 64'hff02_0000_0000_0000,
                               64'h2, 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_WRITE, 8'd11, 8'd120, 64'h2607_f8b0_4005_0802,
                               64'h0000_0000_0000_200e, 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_WRITE, 8'd12, 8'd32, 64'h2002_c0a8_0101_0000,
                               64'h0, 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_WRITE, 8'd13, 8'd96, 64'h3ffe_0000_0000_0000,
                               64'h0000_0001_ffff_ffff, 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_WRITE, 8'd14, 8'd16, 64'h2001_0000_0000_0000,
                               64'h0, 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_WRITE, 8'd15, 8'd0, 64'hdead_beef_cafe_f00d,
                               64'h0123_4567_89ab_cdef, 1'b0, V_DENY});
    // a zero-length prefix in use matches every address
    plan.push_back(plan_row_t'{ROW_REG, OP_WRITE, REG_ENTRY_COUNT, 8'd0, 64'h0, 64'd16,
                               1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_CHECK, 8'd3, 8'd7, 64'h5a5a_5a5a_0000_1111,
                               64'h9999_0000_7777_3333, 1'b1, V_ALLOW});
    plan.push_back(plan_row_t'{ROW_WORD, OP_WRITE, 8'd15, 8'd128, 64'h0, 64'h0, 1'b0,
                               V_DENY});
    // open mode lets anything through
    plan.push_back(plan_row_t'{ROW_REG, OP_WRITE, REG_MODE, 8'd0, 64'h0,
                               64'(MODE_OPEN), 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_CHECK, 8'd0, 8'd0, '1, '1, 1'b1, V_ALLOW});
    // list mode with an oversized count, across the 64/65 bit boundary
    plan.push_back(plan_row_t'{ROW_REG, OP_WRITE, REG_MODE, 8'd0, 64'h0,
                               64'(MODE_LIST), 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_REG, OP_WRITE, REG_ENTRY_COUNT, 8'd0, 64'h0, 64'd31,
                               1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_CHECK, 8'd0, 8'd0, 64'h2001_0db8_aaaa_0000,
                               64'h8000_0000_0000_0001, 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_CHECK, 8'd0, 8'd0, 64'h2001_0db8_aaaa_0000,
                               64'h0000_0000_0000_0001, 1'b0, V_DENY});
    // spare mode code, no entries, local address only; unused index is dropped
    plan.push_back(plan_row_t'{ROW_REG, OP_WRITE, REG_MODE, 8'd0, 64'h0,
                               64'(MODE_SPARE), 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_REG, OP_WRITE, REG_ENTRY_COUNT, 8'd0, 64'h0, 64'd0,
                               1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_REG, OP_WRITE, REG_LOCAL_HI, 8'd0, 64'h0,
                               64'hfedc_0000_1234_8001, 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_REG, OP_WRITE, REG_LOCAL_LO, 8'd0, 64'h0,
                               64'h0123_ffff_0000_4567, 1'b0, V_DENY});
    plan.push_back(plan_row_t'{ROW_REG, OP_WRITE, REG_UNUSED, 8'd0, 64'h0, '1, 1'b0,
                               V_DENY});
    plan.push_back(plan_row_t'{ROW_WORD, OP_CHECK, 8'd0, 8'd0, 64'hfedc_0000_1234_8001,
                               64'h0123_ffff_0000_4567, 1'b1, V_ALLOW_LOCAL});
    plan.push_back(plan_row_t'{ROW_WORD, OP_CHECK, 8'd0, 8'd0, 64'hfedc_0000_1234_8001,
                               64'h0123_ffff_0000_4566, 1'b1, V_DENY});

    // walk the table; register rows only once the block is idle
    prev_reg = 1'b0;
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_REG) begin
        if (!prev_reg) drain_block(DRAIN_CYCLES);
        reg_write(plan[r].sel, plan[r].lo);
      end else begin
        if (prev_reg) cfg_ch.valid <= 1'b0;
        w = '{plan[r].op, plan[r].sel[3:0], plan[r].plen, plan[r].hi, plan[r].lo};
        send_word(w, plan[r].known, plan[r].want);
      end
      prev_reg = (plan[r].kind == ROW_REG);
    end

    // random phases, each with a fresh register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_block(DRAIN_CYCLES);

      pick = $urandom_range(99);
      mode_v = (pick < 12) ? MODE_OPEN : (pick < 40) ? MODE_LOCAL :
               (pick < 80) ? MODE_LIST : MODE_SPARE;
      if (ph == 1) mode_v = MODE_OPEN;
      if (ph == 6) mode_v = MODE_SPARE;
      pick = $urandom_range(99);
      count_v = (pick < 5) ? 5'd0 : (pick < 30) ? 5'd16 :
                (pick < 40) ? 5'($urandom_range(31, 17)) : 5'($urandom_range(15, 1));
      if (ph == 3) count_v = 5'd0;
      if (ph == 5) count_v = 5'd31;

      // junk in the unused upper data bits now and then
      wide = {$urandom, $urandom};
      reg_write(REG_MODE, ($urandom_range(7) == 0) ? {wide[HALF_W-1:MODE_W], mode_v}
                                                  : 64'(mode_v));
      reg_write(REG_ENTRY_COUNT, ($urandom_range(7) == 0) ? {wide[HALF_W-1:COUNT_W], count_v}
                                                         : 64'(count_v));
      // local address: random, a stored entry, or an extreme
      pick = $urandom_range(99);
      a = (pick < 35) ? rand128() : (pick < 70) ? slot_addr[$urandom_range(TABLE_DEPTH - 1)] :
          (pick < 85) ? '0 : '1;
      reg_write(REG_LOCAL_HI, a[ADDR_W-1:HALF_W]);
      reg_write(REG_LOCAL_LO, a[HALF_W-1:0]);
      cfg_ch.valid <= 1'b0;
      steady <= (ph == NO_IDLE_PHASE);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == HOLD_PHASE && k == 10) hold_asked <= hold_asked + 1;
        if (ph == PAUSE_PHASE && k == PHASE_ITEMS / 2) drain_block(0);
        j = $urandom_range(TABLE_DEPTH - 1);
        if ($urandom_range(99) < 30) begin
          // subnet write, prefix mostly mid-range with the extremes mixed in
          pick = $urandom_range(99);
          plen_v = (pick < 3) ? 8'd0 : (pick < 13) ? 8'($urandom_range(255, 129)) :
                   (pick < 28) ? 8'd128 : (pick < 38) ? 8'd64 : 8'($urandom_range(127, 1));
          pick = $urandom_range(99);
          a = (pick < 10) ? acl_local : (pick < 15) ? '0 : (pick < 20) ? '1 :
              (pick < 30) ? (slot_addr[j] | (rand128() & ~lead_ones(slot_pfx[j]))) :
              rand128();
          w = '{OP_WRITE, 4'($urandom), plen_v, a[ADDR_W-1:HALF_W], a[HALF_W-1:0]};
        end else begin
          // check: inside a stored subnet, near the local address, or anywhere
          pick = $urandom_range(99);
          if (pick < 50) begin
            a = slot_addr[j] | (rand128() & ~lead_ones(slot_pfx[j]));
            // near miss: one bit flipped inside the prefix
            if (slot_pfx[j] != 0 && $urandom_range(3) == 0) begin
              bitpos = ADDR_W - 1 - $urandom_range(slot_pfx[j] - 1);
              a[bitpos] = ~a[bitpos];
            end
          end else if (pick < 65) begin
            a = acl_local;
            if ($urandom_range(2) == 0) begin
              bitpos = $urandom_range(ADDR_W - 1);
              a[bitpos] = ~a[bitpos];
            end
          end else begin
            a = rand128();
          end
          w = '{OP_CHECK, 4'($urandom), 8'($urandom), a[ADDR_W-1:HALF_W], a[HALF_W-1:0]};
        end
        send_word(w, 1'b0, V_DENY);
      end
    end

    drain_block(DRAIN_CYCLES);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side: compare each word, then pick the next ready
  initial begin
    verdict_t exp_v;
    int       hold_served;
    int       hold_left;
    hold_served = 0;
    hold_left   = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result word, allowed %0b local_match %0b",
                   $time, out_ch.allowed, out_ch.local_match);
          fail_count++;
        end else begin
          exp_v = verdicts_due.pop_front();
          if (out_ch.allowed !== exp_v.allowed) begin
            $display("%0t: allowed mismatch, expected %0b actual %0b",
                     $time, exp_v.allowed, out_ch.allowed);
            fail_count++;
          end
          if (out_ch.local_match !== exp_v.local_match) begin
            $display("%0t: local_match mismatch, expected %0b actual %0b",
                     $time, exp_v.local_match, out_ch.local_match);
            fail_count++;
          end
        end
      end
      // long back-pressure on request, otherwise random stalls
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // hard stop if the run hangs
  initial begin
    #(LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* subnet_acl_match_unit.f */
+incdir+rtl/core
rtl/core/sam_pkg.sv
rtl/core/sam_if.sv
rtl/core/sam_cfg.sv
rtl/core/sam_dp.sv
rtl/core/sam_ctrl.sv
rtl/core/subnet_acl_match_unit.sv
rtl/core/sam_chk.sv
dv/tb_top.sv
